// ===== hdl/assert_macros.svh =====
// assert_macros.svh: assertion helpers shared by the RGB to HSV pipeline.
// Every user has clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked on every rising edge, off while reset is held.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rth_pkg.sv =====
// rth_pkg: types, constants and the restoring divide step used by the
// RGB to HSV pipeline. No dependencies.
`timescale 1ns / 1ps

package rth_pkg;

	// channel and quotient width; the divide chain has one cell per quotient bit
	localparam int unsigned CH_W    = 8;
	localparam int unsigned NUM_CELLS = CH_W;
	localparam int unsigned BEAT_W  = 3 * CH_W;

	// hue offsets in half degrees
	localparam logic [CH_W-1:0] OFF_RED_WRAP = 8'd180;
	localparam logic [CH_W-1:0] OFF_GREEN    = 8'd60;
	localparam logic [CH_W-1:0] OFF_BLUE     = 8'd120;

	// one division in flight: partial remainder, dividend bits still to
	// shift in, divisor and quotient bits so far
	typedef struct packed {
		logic [CH_W-1:0] rem;
		logic [CH_W-1:0] low;
		logic [CH_W-1:0] dvs;
		logic [CH_W-1:0] quo;
	} lane_t;

	// everything a cell hands to its neighbor
	typedef struct packed {
		lane_t           hue;
		lane_t           sat;
		logic [CH_W-1:0] brightness;
	} stage_t;

	// one restoring divide step: bring down the next dividend bit,
	// subtract the divisor when it fits
	function automatic lane_t div_step(input lane_t a);
		logic [CH_W:0] trial;
		logic [CH_W:0] dvs_x;
		lane_t         r;
		begin
			trial = {a.rem, a.low[CH_W-1]};
			dvs_x = {1'b0, a.dvs};
			r     = a;
			if (trial >= dvs_x) begin
				r.rem = CH_W'(trial - dvs_x);
				r.quo = {a.quo[CH_W-2:0], 1'b1};
			end else begin
				r.rem = trial[CH_W-1:0];
				r.quo = {a.quo[CH_W-2:0], 1'b0};
			end
			r.low = {a.low[CH_W-2:0], 1'b0};
			return r;
		end
	endfunction

endpackage

// ===== hdl/rth_front.sv =====
// rth_front: first pipeline stage; finds max, min, chroma and the hue branch
// and sets up both divisions. Depends on rth_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rth_front import rth_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [CH_W-1:0] red,
	input  logic [CH_W-1:0] green,
	input  logic [CH_W-1:0] blue,
	output logic            out_valid,
	input  logic            out_ready,
	output stage_t          out_data
);

	logic [CH_W-1:0]        mx, mn, chroma;
	logic signed [CH_W:0]   diff;
	logic [CH_W-1:0]        off;
	logic [2*CH_W-1:0]      off_c;
	logic signed [CH_W+9:0] num_full;
	logic [2*CH_W-1:0]      hue_num;
	logic [2*CH_W-1:0]      sat_num;
	stage_t                 nxt;
	logic                   valid_q;
	stage_t                 data_q;

	// max, min and chroma
	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		chroma = mx - mn;
	end

	// hue branch: red wins ties, then green
	always_comb begin
		if (mx == red) begin
			diff = $signed({1'b0, green}) - $signed({1'b0, blue});
			off  = (green < blue) ? OFF_RED_WRAP : '0;
		end else if (mx == green) begin
			diff = $signed({1'b0, blue}) - $signed({1'b0, red});
			off  = OFF_GREEN;
		end else begin
			diff = $signed({1'b0, red}) - $signed({1'b0, green});
			off  = OFF_BLUE;
		end
	end

	// numerators: 30*diff + off*C (never negative, below 180*C) and 255*C
	always_comb begin
		off_c    = {{CH_W{1'b0}}, off} * {{CH_W{1'b0}}, chroma};
		num_full = ($signed((CH_W+10)'(diff)) <<< 5) - ($signed((CH_W+10)'(diff)) <<< 1)
			+ $signed({2'b00, off_c});
		hue_num  = num_full[2*CH_W-1:0];
		sat_num  = {chroma, {CH_W{1'b0}}} - {{CH_W{1'b0}}, chroma};
	end

	// load the lanes; a zero divisor only occurs with a zero numerator
	always_comb begin
		nxt.hue.rem    = hue_num[2*CH_W-1:CH_W];
		nxt.hue.low    = hue_num[CH_W-1:0];
		nxt.hue.dvs    = (chroma == '0) ? CH_W'(1) : chroma;
		nxt.hue.quo    = '0;
		nxt.sat.rem    = sat_num[2*CH_W-1:CH_W];
		nxt.sat.low    = sat_num[CH_W-1:0];
		nxt.sat.dvs    = (mx == '0) ? CH_W'(1) : mx;
		nxt.sat.quo    = '0;
		nxt.brightness = mx;
	end

	assign in_ready = !valid_q || out_ready;

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

	`ASSERT_IMPLY(a_front_rem_below_div, valid_q,
		(data_q.hue.rem < data_q.hue.dvs) && (data_q.sat.rem < data_q.sat.dvs),
		"front: dividend high half not below divisor")

endmodule

// ===== hdl/rth_cell.sv =====
// rth_cell: one cell of the divide chain; resolves one quotient bit of the
// hue and saturation divisions and passes the beat on. Depends on rth_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rth_cell import rth_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  stage_t in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output stage_t out_data
);

	logic   valid_q;
	stage_t data_q;

	// a cell takes a beat when empty or when its neighbor takes its own
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// one divide step on each lane, brightness rides along
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q.hue        <= div_step(in_data.hue);
			data_q.sat        <= div_step(in_data.sat);
			data_q.brightness <= in_data.brightness;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

	`ASSERT_IMPLY(a_cell_hue_rem, valid_q, data_q.hue.rem < data_q.hue.dvs,
		"cell: hue remainder not below divisor")
	`ASSERT_IMPLY(a_cell_sat_rem, valid_q, data_q.sat.rem < data_q.sat.dvs,
		"cell: saturation remainder not below divisor")

endmodule

// ===== hdl/rgb_to_hsv_pixel.sv =====
// Stages: one setup stage, then one cell per quotient bit of the 8-bit divides;
// every accepted input beat is registered in each of them on its way out.
// Throughput: one pixel per clock while m_tready is high; each stage holds one beat and moves on
// when the next stage is empty or moving, so bubbles close up under stall.
// Reset: arst_n clears all stage valid flags; data registers are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgb_to_hsv_pixel import rth_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BEAT_W-1:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BEAT_W-1:0] m_tdata    // hue [7:0], saturation [15:8], brightness [23:16]
);

	logic   link_valid [NUM_CELLS+1];
	logic   link_ready [NUM_CELLS+1];
	stage_t link_data  [NUM_CELLS+1];

	// setup stage
	rth_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.red       (s_tdata[CH_W-1:0]),
		.green     (s_tdata[2*CH_W-1:CH_W]),
		.blue      (s_tdata[3*CH_W-1:2*CH_W]),
		.out_valid (link_valid[0]),
		.out_ready (link_ready[0]),
		.out_data  (link_data[0])
	);

	// divide chain
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		rth_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_valid[i]),
			.in_ready  (link_ready[i]),
			.in_data   (link_data[i]),
			.out_valid (link_valid[i+1]),
			.out_ready (link_ready[i+1]),
			.out_data  (link_data[i+1])
		);
	end

	// last cell register is the output register
	assign link_ready[NUM_CELLS] = m_tready;
	assign m_tvalid = link_valid[NUM_CELLS];
	assign m_tdata  = {link_data[NUM_CELLS].brightness,
		link_data[NUM_CELLS].sat.quo,
		link_data[NUM_CELLS].hue.quo};

	`ASSERT_IMPLY(a_top_hue_range, m_tvalid, m_tdata[CH_W-1:0] <= 8'd179,
		"top: hue out of range")

endmodule
